// ===== sv/tstm_pkg.sv =====
package tstm_pkg;

   // sample width default and fixed field widths
   localparam int SAMPLE_BITS_DEF = 12;
   localparam int POS_BITS        = 12;
   localparam int LIMIT_BITS      = 12;
   localparam logic [LIMIT_BITS-1:0] SPREAD_RESET = LIMIT_BITS'(200);

   // burst geometry
   localparam int BURST_LEN = 10;
   localparam int SORT_LEN  = 9;
   localparam int IDX_BITS  = $clog2(BURST_LEN);
   localparam int RANK_BITS = $clog2(SORT_LEN + 1);

   // sorted positions used by the spread check and the trimmed mean
   localparam int RANK_LO    = 2;
   localparam int RANK_HI    = 7;
   localparam int MEAN_FIRST = 3;
   localparam int MEAN_LAST  = 6;

   // control from the sequencer to each channel's rank unit
   typedef struct packed {
      logic clear;
      logic cand_load;
      logic compare;
      logic tie_wins;
      logic commit;
   } sel_ctl_type;

endpackage

// ===== sv/tstm_ram.sv =====
module tstm_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 10
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/tstm_select.sv =====
module tstm_select #(
   parameter int SAMPLE_BITS = tstm_pkg::SAMPLE_BITS_DEF
) (
   input  logic                            clock,
   input  tstm_pkg::sel_ctl_type           ctl,
   input  logic [SAMPLE_BITS-1:0]          sample,
   input  logic [tstm_pkg::LIMIT_BITS-1:0] limit,
   output logic                            noisy,
   output logic [SAMPLE_BITS-1:0]          mean
);

   localparam int RB       = tstm_pkg::RANK_BITS;
   localparam int SUM_BITS = SAMPLE_BITS + 2;
   localparam int CMP_BITS = (SAMPLE_BITS > tstm_pkg::LIMIT_BITS) ?
                             SAMPLE_BITS : tstm_pkg::LIMIT_BITS;

   logic [SAMPLE_BITS-1:0] cand_ff, cand_in;
   logic [RB-1:0]          rank_ff, rank_in;
   logic [SAMPLE_BITS-1:0] lo_ff, lo_in;
   logic [SAMPLE_BITS-1:0] hi_ff, hi_in;
   logic [SUM_BITS-1:0]    sum_ff, sum_in;
   logic                   less;
   logic [RB-1:0]          rank_next;
   logic [SAMPLE_BITS-1:0] spread;

   // shared compare: does the swept entry sort ahead of the candidate
   assign less      = (sample < cand_ff) || ((sample == cand_ff) && ctl.tie_wins);
   assign rank_next = rank_ff + {{(RB-1){1'b0}}, less};

   // candidate, rank count and selected sorted entries
   always_comb begin
      cand_in = cand_ff;
      rank_in = rank_ff;
      lo_in   = lo_ff;
      hi_in   = hi_ff;
      sum_in  = sum_ff;
      if (ctl.clear) begin
         sum_in = '0;
      end
      if (ctl.cand_load) begin
         cand_in = sample;
         rank_in = '0;
      end
      if (ctl.compare) begin
         rank_in = rank_next;
      end
      if (ctl.commit) begin
         if (rank_next == RB'(tstm_pkg::RANK_LO)) begin
            lo_in = cand_ff;
         end
         if (rank_next == RB'(tstm_pkg::RANK_HI)) begin
            hi_in = cand_ff;
         end
         if ((rank_next >= RB'(tstm_pkg::MEAN_FIRST)) &&
             (rank_next <= RB'(tstm_pkg::MEAN_LAST))) begin
            sum_in = sum_ff + SUM_BITS'(cand_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      cand_ff <= cand_in;
      rank_ff <= rank_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      sum_ff  <= sum_in;
   end

   // spread check and trimmed mean of the four middle entries
   assign spread = hi_ff - lo_ff;
   assign noisy  = CMP_BITS'(spread) > CMP_BITS'(limit);
   assign mean   = sum_ff[SUM_BITS-1:2];

endmodule

// ===== sv/touch_sample_trimmed_mean_filter.sv =====
// channel  | ports                                    | direction
// ---------+------------------------------------------+----------
// request  | req_valid/ready, req_x_sample, req_y_sample | in
// result   | rsp_valid/ready, rsp_x_position,         | out
//          | rsp_y_position, rsp_accepted             |
// csr      | csr_valid/ready, csr_spread_limit        | in
//
// The first nine requests of a burst are only stored and give no result.
// The tenth starts a rank sort over the sample RAM: nine candidates, each read
// and then compared with entries 0 to 8 through its single registered read
// port; no request is taken until the result is posted.
// Reset clears the burst position and the held coordinates and sets the limit to 200.
// A pending result does not block requests; a burst that finishes while the
// previous result still waits holds in its final state until it is taken.
module touch_sample_trimmed_mean_filter #(
   parameter int SAMPLE_BITS = tstm_pkg::SAMPLE_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [SAMPLE_BITS-1:0]          req_x_sample,
   input  logic [SAMPLE_BITS-1:0]          req_y_sample,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [tstm_pkg::POS_BITS-1:0]   rsp_x_position,
   output logic [tstm_pkg::POS_BITS-1:0]   rsp_y_position,
   output logic                            rsp_accepted,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [tstm_pkg::LIMIT_BITS-1:0] csr_spread_limit
);

   localparam int IB = tstm_pkg::IDX_BITS;
   localparam int PB = tstm_pkg::POS_BITS;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SORT = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   localparam logic [IB-1:0] LAST_SAMPLE = IB'(tstm_pkg::BURST_LEN - 1);
   localparam logic [IB-1:0] LAST_CAND   = IB'(tstm_pkg::SORT_LEN - 1);
   localparam logic [IB-1:0] K_LOAD      = IB'(1);
   localparam logic [IB-1:0] K_FIRST_CMP = IB'(2);
   localparam logic [IB-1:0] K_LAST      = IB'(tstm_pkg::SORT_LEN + 1);

   logic [1:0]                      state_ff, state_in;
   logic [IB-1:0]                   index_ff, index_in;
   logic [IB-1:0]                   cand_ff, cand_in;
   logic [IB-1:0]                   step_ff, step_in;
   logic [tstm_pkg::LIMIT_BITS-1:0] limit_ff, limit_in;
   logic [PB-1:0]                   held_x_ff, held_x_in;
   logic [PB-1:0]                   held_y_ff, held_y_in;
   logic                            ok_ff, ok_in;
   logic                            rsp_valid_ff, rsp_valid_in;

   logic                            req_fire;
   logic                            burst_end;
   logic                            post;
   logic [IB-1:0]                   rd_addr;
   logic [2*SAMPLE_BITS-1:0]        rd_data;
   tstm_pkg::sel_ctl_type           ctl;
   logic                            x_noisy, y_noisy;
   logic [SAMPLE_BITS-1:0]          x_mean, y_mean;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign burst_end = req_fire && (index_ff == LAST_SAMPLE);
   assign post      = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
   assign csr_ready = 1'b1;

   // sample RAM, x and y side by side
   tstm_ram #(
      .WIDTH (2 * SAMPLE_BITS),
      .DEPTH (tstm_pkg::BURST_LEN)
   ) u_store (
      .clock   (clock),
      .wr_en   (req_fire),
      .wr_addr (index_ff),
      .wr_data ({req_y_sample, req_x_sample}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // sweep read address: candidate first, then entries 0 to 9 (only 0 to 8 are compared)
   assign rd_addr = (step_ff == '0) ? cand_ff : (step_ff - IB'(1));

   // rank unit control
   always_comb begin
      ctl           = '0;
      ctl.clear     = burst_end;
      if (state_ff == ST_SORT) begin
         ctl.cand_load = (step_ff == K_LOAD);
         ctl.compare   = (step_ff >= K_FIRST_CMP);
         ctl.tie_wins  = (step_ff < (cand_ff + IB'(2)));
         ctl.commit    = (step_ff == K_LAST);
      end
   end

   tstm_select #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_sel_x (
      .clock  (clock),
      .ctl    (ctl),
      .sample (rd_data[SAMPLE_BITS-1:0]),
      .limit  (limit_ff),
      .noisy  (x_noisy),
      .mean   (x_mean)
   );

   tstm_select #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_sel_y (
      .clock  (clock),
      .ctl    (ctl),
      .sample (rd_data[2*SAMPLE_BITS-1:SAMPLE_BITS]),
      .limit  (limit_ff),
      .noisy  (y_noisy),
      .mean   (y_mean)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      index_in = index_ff;
      cand_in  = cand_ff;
      step_in  = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (burst_end) begin
                  index_in = '0;
                  cand_in  = '0;
                  step_in  = '0;
                  state_in = ST_SORT;
               end else begin
                  index_in = index_ff + IB'(1);
               end
            end
         end
         ST_SORT: begin
            if (step_ff == K_LAST) begin
               step_in = '0;
               if (cand_ff == LAST_CAND) begin
                  state_in = ST_DONE;
               end else begin
                  cand_in = cand_ff + IB'(1);
               end
            end else begin
               step_in = step_ff + IB'(1);
            end
         end
         ST_DONE: begin
            if (post) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // held coordinates, result flag and result valid
   always_comb begin
      held_x_in    = held_x_ff;
      held_y_in    = held_y_ff;
      ok_in        = ok_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (post) begin
         ok_in        = !y_noisy && !x_noisy;
         rsp_valid_in = 1'b1;
         if (!y_noisy && !x_noisy) begin
            held_x_in = PB'(x_mean);
            held_y_in = PB'(y_mean);
         end
      end
   end

   // configuration write
   always_comb begin
      limit_in = limit_ff;
      if (csr_valid && csr_ready) begin
         limit_in = csr_spread_limit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         index_ff     <= '0;
         cand_ff      <= '0;
         step_ff      <= '0;
         limit_ff     <= tstm_pkg::SPREAD_RESET;
         held_x_ff    <= '0;
         held_y_ff    <= '0;
         ok_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         index_ff     <= index_in;
         cand_ff      <= cand_in;
         step_ff      <= step_in;
         limit_ff     <= limit_in;
         held_x_ff    <= held_x_in;
         held_y_ff    <= held_y_in;
         ok_ff        <= ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_x_position = held_x_ff;
   assign rsp_y_position = held_y_ff;
   assign rsp_accepted   = ok_ff;

endmodule
